// ===== rtl/core/ffc_pkg.sv =====
// ----------------------------------------------------------------------------
// ffc_pkg
// Operation codes, constants and a shared rounding helper for the float format converter.
// ----------------------------------------------------------------------------
package ffc_pkg;

   typedef enum logic [2:0] {
      FUNC_F32_F16  = 3'd0,
      FUNC_F16_F32  = 3'd1,
      FUNC_F32_BF16 = 3'd2,
      FUNC_F32_E4M3 = 3'd3,
      FUNC_E4M3_F32 = 3'd4
   } func_type;

   localparam logic [31:0] F32_EXP_MASK  = 32'h7F80_0000;
   localparam logic [31:0] F32_QNAN      = 32'h7FC0_0000;
   localparam logic [31:0] BF16_HI_MASK  = 32'hFFFF_0000;
   localparam logic [31:0] BF16_QUIET    = 32'h0001_0000;
   localparam logic [15:0] F16_INF       = 16'h7C00;
   localparam logic [7:0]  E4M3_MAX      = 8'h7E;
   localparam logic [7:0]  E4M3_NAN      = 8'h7F;
   localparam logic [7:0]  EXP_BIAS_DIFF = 8'd112;

   // Round-to-nearest-even on a 24-bit significand shifted right by sh.
   function automatic logic [23:0] rne_shr(input logic [23:0] v, input logic [5:0] sh);
      logic [23:0] t;
      logic [23:0] rem;
      logic [23:0] half;
      logic [23:0] mask;
      if (sh == 6'd0) return v;
      if (sh >= 6'd24) begin
         // only the sticky/half compare matters: result is 0 or 1
         if (sh == 6'd24 && v > 24'h80_0000) return 24'd1;
         return 24'd0;
      end
      t    = v >> sh;
      mask = (24'd1 << sh) - 24'd1;
      rem  = v & mask;
      half = 24'd1 << (sh - 6'd1);
      if (rem > half) return t + 24'd1;
      if (rem < half) return t;
      return t + {23'd0, t[0]};
   endfunction

endpackage

// ===== rtl/core/float_format_converter_top.sv =====
// ----------------------------------------------------------------------------
// float_format_converter_top
// Converts f32 to and from f16 and e4m3fn, and f32 to bf16, RNE on narrowing.
// ----------------------------------------------------------------------------
// One conversion per clock while the response is not stalled:
// stage 1 decodes fields and picks a rounding shift, stage 2 rounds, stage 3
// packs special cases and exponent carries into the result. Each stage has its
// own valid bit; a stall on rsp_ freezes the full pipe, and a bubble in any
// stage is filled while the output waits, so req_stall is high only when the
// whole pipe is occupied and the response is held.
module float_format_converter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [31:0] req_source_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_bits
);

   // stage enables: a stage advances when the one after it is empty or moves
   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;
   assign en3 = !v3_ff || !rsp_stall;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_stall = !en1;

   // ---------------- stage 1: decode
   logic [2:0]  f1_ff;  logic [31:0] s1_ff;
   logic [23:0] sig1_ff, sig1_in;   // significand to round
   logic [5:0]  sh1_ff, sh1_in;     // rounding shift
   always_comb begin
      logic [7:0] ex;
      logic [22:0] fr;
      ex = req_source_bits[30:23];
      fr = req_source_bits[22:0];
      sig1_in = {1'b0, fr};
      sh1_in  = 6'd0;
      unique case (req_func)
         ffc_pkg::FUNC_F32_F16: begin
            if (ex >= 8'd113) begin
               sig1_in = {1'b0, fr}; sh1_in = 6'd13;
            end else if (ex >= 8'd102) begin
               // half exponent in -10..0: shift = 14 - hexp = 126 - ex
               sig1_in = {1'b1, fr};
               sh1_in  = 6'(8'd126 - ex);
            end
         end
         ffc_pkg::FUNC_F32_E4M3: begin
            if (ex >= 8'd121) begin
               sig1_in = {1'b0, fr}; sh1_in = 6'd20;
            end else if (ex != 8'd0) begin
               sig1_in = {1'b1, fr};
               sh1_in  = (ex < 8'd117) ? 6'd25 : 6'(8'd141 - ex);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en1) v1_ff <= req_valid;
      if (en1) begin
         f1_ff <= req_func; s1_ff <= req_source_bits;
         sig1_ff <= sig1_in; sh1_ff <= sh1_in;
      end
   end

   // ---------------- stage 2: round
   logic [2:0]  f2_ff;  logic [31:0] s2_ff;
   logic [23:0] r2_ff;
   logic [31:0] bf2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en2) v2_ff <= v1_ff;
      if (en2) begin
         f2_ff <= f1_ff; s2_ff <= s1_ff;
         r2_ff <= ffc_pkg::rne_shr(sig1_ff, sh1_ff);
         bf2_ff <= s1_ff + 32'h7FFF + {31'd0, s1_ff[16]};
      end
   end

   // ---------------- stage 3: pack
   logic [31:0] res3_ff, res3_in;
   always_comb begin
      logic [7:0]  ex;
      logic [22:0] fr;
      logic        sg;
      logic [7:0]  hexp;
      logic [4:0]  e8;
      logic [15:0] fh;
      logic [4:0]  p;
      logic [9:0]  hfr;
      ex = s2_ff[30:23]; fr = s2_ff[22:0]; sg = s2_ff[31];
      res3_in = 32'd0;
      hexp = 8'd0; e8 = 5'd0; fh = s2_ff[15:0]; p = 5'd0; hfr = 10'd0;
      unique case (f2_ff)
         ffc_pkg::FUNC_F32_F16: begin
            if (ex == 8'hFF) begin
               hfr = (fr[22:13] == 10'd0 && fr != 23'd0) ? 10'd1 : fr[22:13];
               res3_in = {16'd0, sg, 5'h1F, hfr};
            end else if (ex >= 8'd143) begin
               res3_in = {16'd0, sg, ffc_pkg::F16_INF[14:0]};
            end else if (ex >= 8'd113) begin
               hexp = ex - ffc_pkg::EXP_BIAS_DIFF;
               if (r2_ff[10]) hexp = hexp + 8'd1;
               if (hexp >= 8'd31) res3_in = {16'd0, sg, ffc_pkg::F16_INF[14:0]};
               else res3_in = {16'd0, sg, hexp[4:0], r2_ff[9:0] & {10{!r2_ff[10]}}};
            end else if (ex >= 8'd102) begin
               if (r2_ff >= 24'h400) res3_in = {16'd0, sg, 15'h0400};
               else res3_in = {16'd0, sg, r2_ff[14:0]};
            end else res3_in = {16'd0, sg, 15'd0};
         end
         ffc_pkg::FUNC_F16_F32: begin
            if (fh[14:10] == 5'd0) begin
               if (fh[9:0] != 10'd0) begin
                  for (int i = 0; i < 10; i++) if (fh[i]) p = 5'(i);
                  res3_in[31] = fh[15];
                  res3_in[30:23] = 8'({3'd0, p} + 8'd103);
                  res3_in[22:0] = 23'({13'd0, fh[9:0]} << (5'd23 - p));
               end else res3_in = {fh[15], 31'd0};
            end else if (fh[14:10] == 5'h1F)
               res3_in = {fh[15], 8'hFF, fh[9:0], 13'd0};
            else
               res3_in = {fh[15], 8'({3'd0, fh[14:10]} + ffc_pkg::EXP_BIAS_DIFF),
                          fh[9:0], 13'd0};
         end
         ffc_pkg::FUNC_F32_BF16: begin
            if ((s2_ff & ffc_pkg::F32_EXP_MASK) == ffc_pkg::F32_EXP_MASK)
               res3_in = (fr != 23'd0) ? ((s2_ff | ffc_pkg::BF16_QUIET) & ffc_pkg::BF16_HI_MASK)
                                       : (s2_ff & ffc_pkg::BF16_HI_MASK);
            else res3_in = bf2_ff & ffc_pkg::BF16_HI_MASK;
         end
         ffc_pkg::FUNC_F32_E4M3: begin
            if (ex == 8'hFF)
               res3_in = {24'd0, sg, (fr == 23'd0) ? ffc_pkg::E4M3_MAX[6:0]
                                                   : ffc_pkg::E4M3_NAN[6:0]};
            else if (s2_ff[30:0] == 31'd0 || ex == 8'd0) res3_in = {24'd0, sg, 7'd0};
            else if (ex >= 8'd136) res3_in = {24'd0, sg, ffc_pkg::E4M3_MAX[6:0]};
            else if (ex >= 8'd121) begin
               e8 = 5'(ex - 8'd120);
               if (r2_ff[3]) e8 = e8 + 5'd1;
               if (e8 >= 5'd16 || (e8 == 5'd15 && !r2_ff[3] && r2_ff[2:0] == 3'd7))
                  res3_in = {24'd0, sg, ffc_pkg::E4M3_MAX[6:0]};
               else res3_in = {24'd0, sg, e8[3:0], r2_ff[2:0] & {3{!r2_ff[3]}}};
            end else if (r2_ff >= 24'd8) res3_in = {24'd0, sg, 7'h08};
            else res3_in = {24'd0, sg, 4'd0, r2_ff[2:0]};
         end
         ffc_pkg::FUNC_E4M3_F32: begin
            if (s2_ff[6:3] == 4'd0) begin
               if (s2_ff[2:0] != 3'd0) begin
                  for (int i = 0; i < 3; i++) if (s2_ff[i]) p = 5'(i);
                  res3_in = {s2_ff[7], 8'({3'd0, p} + 8'd118),
                             23'({20'd0, s2_ff[2:0]} << (5'd23 - p))};
               end else res3_in = {s2_ff[7], 31'd0};
            end else if (s2_ff[6:0] == 7'h7F) res3_in = ffc_pkg::F32_QNAN;
            else res3_in = {s2_ff[7], 8'({4'd0, s2_ff[6:3]} + 8'd120), s2_ff[2:0], 20'd0};
         end
         default: res3_in = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en3) v3_ff <= v2_ff;
      if (en3) res3_ff <= res3_in;
   end

   assign rsp_valid       = v3_ff;
   assign rsp_result_bits = res3_ff;

   // a held response does not change
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_bits))
      else $error("response changed under stall");
   // input is refused only when the output is stalled
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("spurious request stall");
   // a full pipe must stall the request when the response waits
   a_full: assert property (@(posedge clock) disable iff (reset)
      v1_ff && v2_ff && v3_ff && rsp_stall |-> req_stall)
      else $error("overrun of full pipe");

endmodule
